// File: src/psfp_pkg.sv
// Shared constants and types for the particle sensor frame parser.
// No dependencies; imported by every module of the block.
package psfp_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int FIELD_W     = 4;
  localparam int VALUE_W     = 16;

  localparam logic [7:0] MARK_FIRST  = 8'h42;
  localparam logic [7:0] MARK_SECOND = 8'h4D;

  localparam logic [IDX_W-1:0] POS_MARK_HI = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_MARK_LO = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_CKS_HI  = IDX_W'(FRAME_BYTES - 2);
  localparam logic [IDX_W-1:0] POS_CKS_LO  = IDX_W'(FRAME_BYTES - 1);

  localparam logic [FIELD_W-1:0] WORD_FIELDS = FIELD_W'(12);
  localparam logic [FIELD_W-1:0] LAST_FIELD  = FIELD_W'(13);

  localparam logic [2:0] REG_ENABLE_ADDR = 3'd0;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr0;
    logic [IDX_W-1:0] addr1;
  } mem_rd_t;

endpackage

// File: src/particle_sensor_frame_parser.sv
// Top level of the particle sensor frame parser: byte stream in, decoded fields out.
// Depends on psfp_pkg, psfp_store, psfp_rx and psfp_emit.
//
// Usage:
//   in_*  : one received serial byte per beat (in_tdata[7:0]).
//   out_* : one decoded field per beat; out_tuser[3:0] field index,
//           out_tdata[15:0] field value; out_tlast marks the error-code field.
//   cfg_* : register 0 (address 0) bit 0 enables the parser; reset value 1.
//           While clear, input beats are taken and discarded.
// Throughput: one input byte per cycle while a frame fills. The beat that
//   completes a valid 32-byte frame starts the field sequencer, which does a
//   store read, then an output load, for each of the 14 fields; in_tready is
//   low from the cycle after that beat until the last field is loaded into
//   the output register.
// First field: via the frame check register and the sequencer's wait and load states.
// Reset: synchronous, active low; fill index, previous byte and output valid
//   clear; the output data and the store contents are left as they are.
// Stall: a held output beat stops the sequencer, and with it the input
//   side while fields remain; frames with a bad header or checksum yield no
//   beats and do not stall the input.
module particle_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] field_value
  output logic [3:0]  out_tuser,  // [3:0] field_index
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import psfp_pkg::*;

  logic               enable_r, enable_nxt;
  logic               cfg_wr;
  logic               beat;
  logic               frame_ok;
  logic               emit_idle;
  mem_wr_t            wr;
  mem_rd_t            rd;
  logic [7:0]         rd_data0;
  logic [7:0]         rd_data1;
  logic [FIELD_W-1:0] out_index;
  logic [VALUE_W-1:0] out_value;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign enable_nxt = (cfg_wr && (cfg_paddr == REG_ENABLE_ADDR)) ? cfg_pwdata[0] : enable_r;
  assign cfg_prdata = (cfg_paddr == REG_ENABLE_ADDR) ? {31'b0, enable_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  assign in_tready = emit_idle && !frame_ok;
  assign beat      = in_tvalid && in_tready && enable_r;

  psfp_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd       (rd),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  psfp_rx u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .rx_byte  (in_tdata),
    .wr       (wr),
    .frame_ok (frame_ok)
  );

  psfp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (frame_ok),
    .rd_data0  (rd_data0),
    .rd_data1  (rd_data1),
    .rd        (rd),
    .idle      (emit_idle),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = out_value;
  assign out_tuser = out_index;

endmodule

// File: src/psfp_store.sv
// Frame byte store: one write port, two registered read ports.
// Depends on psfp_pkg.
module psfp_store (
  input  logic              clk,
  input  psfp_pkg::mem_wr_t wr,
  input  psfp_pkg::mem_rd_t rd,
  output logic [7:0]        rd_data0,
  output logic [7:0]        rd_data1
);
  import psfp_pkg::*;

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data0_r;
  logic [7:0] rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data0_r <= mem[rd.addr0];
    rd_data1_r <= mem[rd.addr1];
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// File: src/psfp_rx.sv
// Byte intake: resync on start marker, fill index, running checksum, frame check.
// Depends on psfp_pkg; drives the write port of psfp_store.
module psfp_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [7:0]        rx_byte,
  output psfp_pkg::mem_wr_t wr,
  output logic              frame_ok
);
  import psfp_pkg::*;

  logic [IDX_W-1:0]   fill_r, fill_nxt;
  logic [7:0]         prev_r, prev_nxt;
  logic [VALUE_W-1:0] sum_r, sum_nxt;
  logic [7:0]         cks_hi_r, cks_hi_nxt;
  logic               hdr0_r, hdr0_nxt;
  logic               hdr1_r, hdr1_nxt;
  logic               ok_r, ok_nxt;
  logic               marker;
  logic [IDX_W-1:0]   idx;

  assign marker = (rx_byte == MARK_SECOND) && (prev_r == MARK_FIRST);
  assign idx    = marker ? POS_MARK_LO : fill_r;

  always_comb begin
    fill_nxt   = fill_r;
    prev_nxt   = prev_r;
    sum_nxt    = sum_r;
    cks_hi_nxt = cks_hi_r;
    hdr0_nxt   = hdr0_r;
    hdr1_nxt   = hdr1_r;
    ok_nxt     = 1'b0;
    if (beat) begin
      fill_nxt = idx + IDX_W'(1);
      prev_nxt = rx_byte;
      if (marker) begin
        sum_nxt  = VALUE_W'(MARK_FIRST) + VALUE_W'(MARK_SECOND);
        hdr0_nxt = 1'b1;
        hdr1_nxt = 1'b1;
      end else if (idx == POS_MARK_HI) begin
        sum_nxt  = VALUE_W'(rx_byte);
        hdr0_nxt = (rx_byte == MARK_FIRST);
      end else if (idx < POS_CKS_HI) begin
        sum_nxt = sum_r + VALUE_W'(rx_byte);
        if (idx == POS_MARK_LO) begin
          hdr1_nxt = (rx_byte == MARK_SECOND);
        end
      end else if (idx == POS_CKS_HI) begin
        cks_hi_nxt = rx_byte;
      end else begin
        ok_nxt = hdr0_r && hdr1_r && (sum_r == {cks_hi_r, rx_byte});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      prev_r <= '0;
      ok_r   <= 1'b0;
      hdr0_r <= 1'b0;
      hdr1_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      prev_r <= prev_nxt;
      ok_r   <= ok_nxt;
      hdr0_r <= hdr0_nxt;
      hdr1_r <= hdr1_nxt;
    end
    sum_r    <= sum_nxt;
    cks_hi_r <= cks_hi_nxt;
  end

  assign wr.en    = beat;
  assign wr.addr  = idx;
  assign wr.data  = rx_byte;
  assign frame_ok = ok_r;

`ifndef SYNTHESIS
  a_ok_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ok_r |-> ($past(beat) && ($past(idx) == POS_CKS_LO)))
    else $error("frame check fired without a final byte");
  a_fill_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    beat && (idx == POS_CKS_LO) |=> (fill_r == '0))
    else $error("fill index did not restart after full frame");
  a_marker_pos: assert property (@(posedge clk) disable iff (!rst_n)
    beat && marker |=> (fill_r == IDX_W'(2)) && hdr0_r && hdr1_r)
    else $error("start marker did not resync frame");
`endif

endmodule

// File: src/psfp_emit.sv
// Result sequencer: reads the stored frame field by field into the output register.
// Depends on psfp_pkg; drives the read ports of psfp_store.
module psfp_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [7:0]                    rd_data0,
  input  logic [7:0]                    rd_data1,
  output psfp_pkg::mem_rd_t             rd,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psfp_pkg::FIELD_W-1:0]  out_index,
  output logic [psfp_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_last
);
  import psfp_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_WAIT = 3'b010,
    E_LOAD = 3'b100
  } emit_state_t;

  emit_state_t        state_r, state_nxt;
  logic [FIELD_W-1:0] k_r, k_nxt;
  logic               valid_r, valid_nxt;
  logic [FIELD_W-1:0] index_r, index_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               last_r, last_nxt;
  logic               load;
  logic               word;

  assign word     = (k_r < WORD_FIELDS);
  assign rd.addr0 = word ? IDX_W'(5'd4 + {k_r, 1'b0}) : IDX_W'(5'd16 + 5'(k_r));
  assign rd.addr1 = IDX_W'(5'd5 + {k_r, 1'b0});
  assign load     = (state_r == E_LOAD) && (!valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    valid_nxt = valid_r && !out_ready;
    index_nxt = index_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          k_nxt     = '0;
          state_nxt = E_WAIT;
        end
      end
      E_WAIT: begin
        state_nxt = E_LOAD;
      end
      E_LOAD: begin
        if (load) begin
          valid_nxt = 1'b1;
          index_nxt = k_r;
          value_nxt = word ? {rd_data0, rd_data1} : {8'h00, rd_data0};
          last_nxt  = (k_r == LAST_FIELD);
          k_nxt     = k_r + FIELD_W'(1);
          state_nxt = (k_r == LAST_FIELD) ? E_IDLE : E_WAIT;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
    end
    index_r <= index_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign idle      = (state_r == E_IDLE);
  assign out_valid = valid_r;
  assign out_index = index_r;
  assign out_value = value_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == E_IDLE))
    else $error("frame completed while fields still draining");
  a_last_field: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && last_r |-> (index_r == LAST_FIELD))
    else $error("last flag on wrong field");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    load && (k_r == LAST_FIELD) |=> (state_r == E_IDLE) && last_r && valid_r)
    else $error("sequencer did not finish on final field");
`endif

endmodule

// File: test/psfp_field_check.sv
// Field checker for the particle sensor frame parser: watches the byte, field and register
// channels, predicts the decoded fields of every frame and compares them beat by beat.
// Depends on psfp_pkg.
module psfp_field_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          fields_pending
);
  import psfp_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] num;
    logic [VALUE_W-1:0] value;
    logic               tail;
  } field_t;

  logic [7:0] frame_copy [FRAME_BYTES];
  logic [5:0] fill_pos;
  logic [7:0] prior_byte;
  logic       parse_on;
  field_t     due_fields [$];
  field_t     want;
  int         errors = 0;

  task automatic parse_byte(input logic [7:0] rx);
    logic [15:0] running_sum;
    field_t      f;
    int          i;
    int          k;
    if (rx == MARK_SECOND && prior_byte == MARK_FIRST) begin
      frame_copy[POS_MARK_HI] = MARK_FIRST;
      fill_pos = 6'd1;
    end
    frame_copy[fill_pos[4:0]] = rx;
    fill_pos = fill_pos + 6'd1;
    prior_byte = rx;
    if (fill_pos < FRAME_BYTES) return;
    fill_pos = '0;
    if (frame_copy[POS_MARK_HI] != MARK_FIRST || frame_copy[POS_MARK_LO] != MARK_SECOND) return;
    running_sum = '0;
    for (i = 0; i < FRAME_BYTES - 2; i++)
      running_sum = running_sum + 16'(frame_copy[i]);
    if (running_sum != {frame_copy[POS_CKS_HI], frame_copy[POS_CKS_LO]}) return;
    for (k = 0; k <= LAST_FIELD; k++) begin
      f.num = FIELD_W'(k);
      if (k < WORD_FIELDS)
        f.value = {frame_copy[4 + 2 * k], frame_copy[5 + 2 * k]};
      else
        f.value = {8'h00, frame_copy[FRAME_BYTES - 4 + k - WORD_FIELDS]};
      f.tail = (k == LAST_FIELD);
      due_fields.push_back(f);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (frame_copy[i]) frame_copy[i] = 8'h00;
      fill_pos = '0;
      prior_byte = 8'h00;
      parse_on = 1'b1;
      due_fields.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_fields.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected field beat: idx %0d value %04h last %0b",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want = due_fields.pop_front();
          if (out_tuser != want.num || out_tdata != want.value || out_tlast != want.tail) begin
            errors++;
            if (errors <= 10)
              $display("field mismatch: expected %0d/%04h/%0b, got %0d/%04h/%0b",
                       want.num, want.value, want.tail,
                       out_tuser, out_tdata, out_tlast);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == REG_ENABLE_ADDR)
        parse_on = cfg_pwdata[0];
      if (in_tvalid && in_tready && parse_on)
        parse_byte(in_tdata);
    end
    mismatch_count <= errors;
    fields_pending <= due_fields.size();
  end

endmodule

// File: test/tb_particle_sensor_frame_parser.sv
// Testbench top for the particle sensor frame parser: drives sensor bytes, register writes and
// receiver stalls, and gives the verdict. Depends on psfp_pkg, psfp_field_check and the block.
module tb_particle_sensor_frame_parser;
  import psfp_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_BYTES = 32;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;    // [15:0] field_value
  logic [3:0]  out_tuser;    // [3:0] field_index
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         fail_count;
  int         expected_left;
  int         quiet_cycles = 0;
  logic [7:0] tx_frame [FRAME_BYTES];

  particle_sensor_frame_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  psfp_field_check field_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatch_count(fail_count), .fields_pending(expected_left)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame(input int count);
    int i;
    for (i = 0; i < count; i++) send_byte(tx_frame[i]);
  endtask

  task automatic build_frame(input int fill_mode);
    logic [15:0] running_sum;
    bit          clash;
    int          i;
    do begin
      tx_frame[0] = MARK_FIRST;
      tx_frame[1] = MARK_SECOND;
      for (i = 2; i < FRAME_BYTES - 2; i++)
        tx_frame[i] = (fill_mode == FILL_ZERO) ? 8'h00 :
                      (fill_mode == FILL_ONES) ? 8'hFF : 8'($urandom);
      running_sum = '0;
      for (i = 0; i < FRAME_BYTES - 2; i++)
        running_sum = running_sum + 16'(tx_frame[i]);
      tx_frame[FRAME_BYTES - 2] = running_sum[15:8];
      tx_frame[FRAME_BYTES - 1] = running_sum[7:0];
      clash = 1'b0;
      for (i = 2; i < FRAME_BYTES; i++)
        if (tx_frame[i - 1] == MARK_FIRST && tx_frame[i] == MARK_SECOND) clash = 1'b1;
    end while (clash);
  endtask

  task automatic write_enable(input logic value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_ENABLE_ADDR;
    cfg_pwdata <= {31'b0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int phase;
    int phase_bytes;
    int pick;
    int fill_pick;
    int cut;
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    write_enable(1'b1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // stray bytes, then a marker mid-frame that opens an all-ones frame
        send_byte(8'hFF);
        send_byte(8'h00);
        build_frame(FILL_ONES);
        send_frame(FRAME_BYTES);
      end

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        pick = $urandom_range(99);
        fill_pick = $urandom_range(9);
        build_frame(fill_pick == 0 ? FILL_ZERO : fill_pick == 1 ? FILL_ONES : FILL_RANDOM);
        cut = FRAME_BYTES;
        if (pick < 60) begin
        end else if (pick < 70) begin
          tx_frame[$urandom_range(FRAME_BYTES - 2, FRAME_BYTES - 1)] ^= 8'($urandom_range(1, 255));
        end else if (pick < 78) begin
          tx_frame[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end else if (pick < 88) begin
          cut = $urandom_range(3, FRAME_BYTES - 1);
        end else begin
          cut = $urandom_range(1, 40);
          for (k = 0; k < cut; k++) tx_frame[k % FRAME_BYTES] = 8'($urandom);
        end
        if (pick < 88) begin
          send_frame(cut);
        end else begin
          for (k = 0; k < cut; k++) send_byte(8'($urandom));
        end
        phase_bytes += cut;
      end

      drain();
      write_enable(1'b0);
      build_frame(FILL_RANDOM);
      send_frame(FRAME_BYTES);
      for (k = 0; k < 6; k++) send_byte(8'($urandom));
      drain();
      write_enable(1'b1);
    end

    if (fail_count == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
